>>> src/ptfi_pkg.sv
// Shared constants, types and helper functions for the polarization
// time/frequency integrator. No dependencies.
package ptfi_pkg;

  localparam int DEF_MAX_OUT_CHANNELS = 1024;
  localparam int DEF_MAX_POLS         = 4;
  localparam int DEF_MAX_INT          = 64;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 29;
  localparam int FRAC_W    = 8;
  localparam int NUM_W     = ACC_W + FRAC_W;
  localparam int AVG_W     = 25;
  localparam int CHAN_W    = 10;
  localparam int POL_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  localparam int INT_TIME_W     = 7;
  localparam int INT_FREQ_W     = 7;
  localparam int OUT_CHANNELS_W = 11;
  localparam int NUM_POLS_W     = 3;
  localparam int MODE_W         = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INT_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_FREQ     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_U8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S8  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_U16 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_S16 = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  function automatic logic [15:0] clamp_cfg(input logic [15:0] v, input logic [15:0] hi);
    logic [15:0] r;
    if (v == 16'd0) begin
      r = 16'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] decode_sample(input logic [MODE_W-1:0] mode,
                                                            input logic [SAMPLE_W-1:0] raw);
    logic signed [ACC_W-1:0] r;
    unique case (mode)
      MODE_U8:  r = $signed({{(ACC_W-8){1'b0}}, raw[7:0]});
      MODE_S8:  r = $signed({{(ACC_W-8){raw[7]}}, raw[7:0]});
      MODE_U16: r = $signed({{(ACC_W-16){1'b0}}, raw});
      MODE_S16: r = $signed({{(ACC_W-16){raw[15]}}, raw});
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/polarization_time_freq_integrator.sv
// Polarization-split time/frequency integrating averager.
// A sample that does not close a group passes the accumulator read-modify-write stage, and such
// samples stream at one per cycle while no closing sample blocks input. A closing sample blocks
// input while it passes the accumulator update, the bit-serial divider and the load of the output
// register, and longer while an earlier beat waits at the output.
// Synchronous reset clears positions, registers and handshakes; the accumulator memory is not
// cleared, since the first sample of every group overwrites its entry.
module polarization_time_freq_integrator #(
  parameter int MAX_OUT_CHANNELS = ptfi_pkg::DEF_MAX_OUT_CHANNELS,
  parameter int MAX_POLS         = ptfi_pkg::DEF_MAX_POLS,
  parameter int MAX_INT          = ptfi_pkg::DEF_MAX_INT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // sample[15:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,   // average[24:0], channel[34:25], zero
  output logic [ptfi_pkg::POL_W-1:0]          m_tuser,   // polarization[1:0]
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptfi_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import ptfi_pkg::*;

  localparam int DEPTH = MAX_OUT_CHANNELS * MAX_POLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int PW    = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
  localparam int TW    = (MAX_INT > 1) ? $clog2(MAX_INT) : 1;
  localparam int IW    = $clog2(MAX_INT + 1);
  localparam int DEN_W = 2 * IW;

  logic [INT_TIME_W-1:0]     int_time;
  logic [INT_FREQ_W-1:0]     int_freq;
  logic [OUT_CHANNELS_W-1:0] out_channels;
  logic [NUM_POLS_W-1:0]     num_pols;
  logic [MODE_W-1:0]         sample_mode;

  logic [PW-1:0] pol_pos, pol_pos_next;
  logic [TW-1:0] freq_pos, freq_pos_next;
  logic [CW-1:0] chan_pos, chan_pos_next;
  logic [TW-1:0] time_pos, time_pos_next;

  logic [15:0] nt, nf, nc, np;
  logic        pol_wrap, freq_wrap, chan_wrap, time_wrap;
  logic        accept;
  logic [AW-1:0] addr_now;

  logic                    s1_valid;
  logic [AW-1:0]           s1_addr;
  logic signed [ACC_W-1:0] s1_sample;
  logic                    s1_first;
  logic                    s1_close;
  logic [CHAN_W-1:0]       s1_chan;
  logic [POL_W-1:0]        s1_pol;
  logic                    s1_eos;
  logic                    s1_fwd;
  logic signed [ACC_W-1:0] s1_fwd_data;

  logic signed [ACC_W-1:0] ram_rdata;
  logic signed [ACC_W-1:0] acc_old;
  logic signed [ACC_W-1:0] acc_sum;

  logic [CHAN_W-1:0] res_chan;
  logic [POL_W-1:0]  res_pol;
  logic              res_eos;

  logic              div_start, div_busy, div_done, div_ack;
  logic [AVG_W-1:0]  div_quotient;
  logic [DEN_W-1:0]  den;

  logic [AVG_W-1:0]  out_avg;
  logic [CHAN_W-1:0] out_chan;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_time     <= INT_TIME_W'(1);
      int_freq     <= INT_FREQ_W'(1);
      out_channels <= OUT_CHANNELS_W'(1024);
      num_pols     <= NUM_POLS_W'(1);
      sample_mode  <= MODE_U8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INT_TIME:     int_time     <= cfg_data[INT_TIME_W-1:0];
        REG_INT_FREQ:     int_freq     <= cfg_data[INT_FREQ_W-1:0];
        REG_OUT_CHANNELS: out_channels <= cfg_data[OUT_CHANNELS_W-1:0];
        REG_NUM_POLS:     num_pols     <= cfg_data[NUM_POLS_W-1:0];
        REG_SAMPLE_MODE:  sample_mode  <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign nt  = clamp_cfg(16'(int_time), 16'(MAX_INT));
  assign nf  = clamp_cfg(16'(int_freq), 16'(MAX_INT));
  assign nc  = clamp_cfg(16'(out_channels), 16'(MAX_OUT_CHANNELS));
  assign np  = clamp_cfg(16'(num_pols), 16'(MAX_POLS));
  assign den = DEN_W'(nt[IW-1:0] * nf[IW-1:0]);

  assign pol_wrap  = (16'(pol_pos) + 16'd1) >= np;
  assign freq_wrap = (16'(freq_pos) + 16'd1) >= nf;
  assign chan_wrap = (16'(chan_pos) + 16'd1) >= nc;
  assign time_wrap = (16'(time_pos) + 16'd1) >= nt;

  always_comb begin
    pol_pos_next  = pol_pos;
    freq_pos_next = freq_pos;
    chan_pos_next = chan_pos;
    time_pos_next = time_pos;
    if (accept) begin
      pol_pos_next = pol_wrap ? '0 : pol_pos + PW'(1);
      if (pol_wrap) begin
        freq_pos_next = freq_wrap ? '0 : freq_pos + TW'(1);
        if (freq_wrap) begin
          chan_pos_next = chan_wrap ? '0 : chan_pos + CW'(1);
          if (chan_wrap) begin
            time_pos_next = time_wrap ? '0 : time_pos + TW'(1);
          end
        end
      end
    end
  end

  assign s_tready = !div_busy && !div_done && !(s1_valid && s1_close);
  assign accept   = s_tvalid && s_tready;
  assign addr_now = AW'(32'(chan_pos) * MAX_POLS + 32'(pol_pos));

  always_ff @(posedge clk) begin
    if (rst) begin
      pol_pos  <= '0;
      freq_pos <= '0;
      chan_pos <= '0;
      time_pos <= '0;
      s1_valid <= 1'b0;
    end else begin
      pol_pos  <= pol_pos_next;
      freq_pos <= freq_pos_next;
      chan_pos <= chan_pos_next;
      time_pos <= time_pos_next;
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr     <= addr_now;
      s1_sample   <= decode_sample(sample_mode, s_tdata);
      s1_first    <= (time_pos == '0) && (freq_pos == '0);
      s1_close    <= time_wrap && freq_wrap;
      s1_chan     <= CHAN_W'(chan_pos);
      s1_pol      <= POL_W'(pol_pos);
      s1_eos      <= chan_wrap && pol_wrap;
      s1_fwd      <= s1_valid && (addr_now == s1_addr);
      s1_fwd_data <= acc_sum;
    end
  end

  ptfi_ram #(
    .WIDTH(ACC_W),
    .DEPTH(DEPTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_addr),
    .wdata(acc_sum),
    .raddr(addr_now),
    .rdata(ram_rdata)
  );

  assign acc_old = s1_fwd ? s1_fwd_data : ram_rdata;
  assign acc_sum = s1_first ? s1_sample : acc_old + s1_sample;

  assign div_start = s1_valid && s1_close;

  always_ff @(posedge clk) begin
    if (div_start) begin
      res_chan <= s1_chan;
      res_pol  <= s1_pol;
      res_eos  <= s1_eos;
    end
  end

  ptfi_div #(
    .DEN_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     ({acc_sum, {FRAC_W{1'b0}}}),
    .den     (den),
    .ack     (div_ack),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quotient)
  );

  assign div_ack = div_done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ack) begin
      out_avg  <= div_quotient;
      out_chan <= res_chan;
      m_tuser  <= res_pol;
      m_tlast  <= res_eos;
    end
  end

  assign m_tdata = {5'd0, out_chan, out_avg};

endmodule

>>> src/ptfi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; contents are undefined after reset.
module ptfi_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ptfi_div.sv
// Restoring divider, one quotient bit per cycle, giving the floored and
// saturated average of a signed sum. Depends on ptfi_pkg.
module ptfi_div #(
  parameter int DEN_W = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ptfi_pkg::NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]                   den,
  input  logic                               ack,
  output logic                               busy,
  output logic                               done,
  output logic [ptfi_pkg::AVG_W-1:0]         quotient
);
  import ptfi_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic signed [NUM_W:0] AVG_MAX = (NUM_W + 1)'((1 << (AVG_W - 1)) - 1);
  localparam logic signed [NUM_W:0] AVG_MIN = -(NUM_W + 1)'(1 << (AVG_W - 1));

  div_state_t       state, state_next;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_diff;
  logic                ge;
  logic signed [NUM_W:0] q_signed;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign ge       = rem_sh >= {1'b0, den_r};

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == CNT_W'(NUM_W - 1)) state_next = DIV_DONE;
      DIV_DONE: if (ack) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      DIV_IDLE: busy = 1'b0;
      DIV_RUN:  busy = 1'b1;
      DIV_DONE: done = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      neg   <= num[NUM_W-1];
      quo   <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
      rem   <= '0;
      den_r <= den;
      cnt   <= '0;
    end else if (state == DIV_RUN) begin
      rem <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_comb begin
    if (!neg) begin
      q_signed = $signed({1'b0, quo});
    end else if (rem != '0) begin
      q_signed = $signed(~{1'b0, quo});
    end else begin
      q_signed = $signed(~{1'b0, quo} + (NUM_W + 1)'(1));
    end
    if (q_signed > AVG_MAX) begin
      quotient = AVG_MAX[AVG_W-1:0];
    end else if (q_signed < AVG_MIN) begin
      quotient = AVG_MIN[AVG_W-1:0];
    end else begin
      quotient = q_signed[AVG_W-1:0];
    end
  end

endmodule
